// ===== hw/rtl/ihex_pkg.sv =====
// shared types and constants for the intel hex record parser
`timescale 1ns / 1ps

package ihex_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] NIBBLE_A = 8'd10;

   localparam logic [7:0] TYPE_DATA = 8'd0;
   localparam logic [7:0] TYPE_EOF  = 8'd1;

   localparam logic [2:0] KIND_DATA  = 3'd0;
   localparam logic [2:0] KIND_OK    = 3'd1;
   localparam logic [2:0] KIND_EOF   = 3'd2;
   localparam logic [2:0] KIND_BAD   = 3'd3;
   localparam logic [2:0] KIND_FRAME = 3'd4;

   typedef enum logic [7:0] {
      PH_START = 8'b0000_0001,
      PH_COUNT = 8'b0000_0010,
      PH_ADDR  = 8'b0000_0100,
      PH_TYPE  = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_CSUM  = 8'b0010_0000,
      PH_SKIP  = 8'b0100_0000,
      PH_HALT  = 8'b1000_0000
   } phase_type;

   // one classified character word as it moves from front to back
   typedef struct packed {
      logic       new_file;
      logic       is_colon;
      logic [7:0] nib;
   } word_type;

endpackage

// ===== hw/rtl/ihex_front.sv =====
// front end: classifies each character word and decodes its digit value
`timescale 1ns / 1ps

module ihex_front
   import ihex_pkg::*;
(
   input  logic [7:0] char_in,
   input  logic       new_file,
   output word_type   word
);

   always_comb begin
      word.new_file = new_file;
      word.is_colon = (char_in == CHAR_COLON);
      if ((char_in >= CHAR_UPPER_A) && (char_in <= CHAR_UPPER_F)) begin
         word.nib = char_in - CHAR_UPPER_A + NIBBLE_A;
      end else begin
         word.nib = char_in - CHAR_ZERO;
      end
   end

endmodule

// ===== hw/rtl/ihex_queue.sv =====
// short word queue between the front end and the record engine
`timescale 1ns / 1ps

module ihex_queue
   import ihex_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output word_type head_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   word_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_word  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hw/rtl/ihex_back.sv =====
// record engine: field assembly, checksum and result register
`timescale 1ns / 1ps

module ihex_back
   import ihex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        word_valid,
   input  word_type    word,
   output logic        word_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_record_checksum,
   output logic [7:0]  rsp_computed_checksum,
   output logic [7:0]  rsp_first_data_length
);

   phase_type   phase_ff, phase_in, cur_phase;
   logic [7:0]  high_ff, high_in, cur_high;
   logic [1:0]  dc_ff, dc_in, cur_dc, dc_inc;
   logic [7:0]  count_ff, count_in, cur_count;
   logic [15:0] addr_ff, addr_in, cur_addr;
   logic [7:0]  rtype_ff, rtype_in, cur_rtype;
   logic [7:0]  idx_ff, idx_in, cur_idx, idx_inc;
   logic [7:0]  sum_ff, sum_in, cur_sum;
   logic [7:0]  flen_ff, flen_in, cur_flen;
   logic        seen_ff, seen_in, cur_seen;

   logic        res_valid;
   logic [2:0]  res_kind;
   logic [7:0]  res_data;
   logic [15:0] res_addr;
   logic [7:0]  res_type;
   logic [7:0]  res_rsum;
   logic [7:0]  res_csum;
   logic [7:0]  b;
   logic [7:0]  comp;

   logic        rsp_valid_ff;
   logic [2:0]  kind_ff;
   logic [7:0]  data_ff;
   logic [15:0] baddr_ff;
   logic [7:0]  otype_ff;
   logic [7:0]  rsum_ff;
   logic [7:0]  csum_ff;
   logic [7:0]  oflen_ff;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign word_pop = word_valid && out_free;

   always_comb begin
      // new_file clears everything before the character is used
      cur_phase = word.new_file ? PH_START : phase_ff;
      cur_high  = word.new_file ? 8'd0 : high_ff;
      cur_dc    = word.new_file ? 2'd0 : dc_ff;
      cur_count = word.new_file ? 8'd0 : count_ff;
      cur_addr  = word.new_file ? 16'd0 : addr_ff;
      cur_rtype = word.new_file ? 8'd0 : rtype_ff;
      cur_idx   = word.new_file ? 8'd0 : idx_ff;
      cur_sum   = word.new_file ? 8'd0 : sum_ff;
      cur_flen  = word.new_file ? 8'd0 : flen_ff;
      cur_seen  = word.new_file ? 1'b0 : seen_ff;

      phase_in = cur_phase;
      high_in  = cur_high;
      dc_in    = cur_dc;
      count_in = cur_count;
      addr_in  = cur_addr;
      rtype_in = cur_rtype;
      idx_in   = cur_idx;
      sum_in   = cur_sum;
      flen_in  = cur_flen;
      seen_in  = cur_seen;

      res_valid = 1'b0;
      res_kind  = KIND_DATA;
      res_data  = 8'd0;
      res_addr  = 16'd0;
      res_type  = 8'd0;
      res_rsum  = 8'd0;
      res_csum  = 8'd0;

      dc_inc  = cur_dc + 2'd1;
      idx_inc = cur_idx + 8'd1;
      b       = {cur_high[3:0], 4'b0000} + word.nib;
      comp    = ~cur_sum + 8'd1;

      case (cur_phase)
         PH_HALT: begin
         end
         PH_SKIP: begin
            phase_in = PH_START;
         end
         PH_START: begin
            if (word.is_colon) begin
               phase_in = PH_COUNT;
               dc_in    = 2'd0;
               sum_in   = 8'd0;
               idx_in   = 8'd0;
            end else begin
               phase_in  = PH_HALT;
               res_valid = 1'b1;
               res_kind  = KIND_FRAME;
            end
         end
         PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
            dc_in = dc_inc;
            if (!cur_dc[0]) begin
               high_in = word.nib;
            end else begin
               case (cur_phase)
                  PH_COUNT: begin
                     count_in = b;
                     sum_in   = cur_sum + b;
                     dc_in    = 2'd0;
                     phase_in = PH_ADDR;
                  end
                  PH_ADDR: begin
                     sum_in = cur_sum + b;
                     if (dc_inc == 2'd2) begin
                        addr_in = {8'd0, b};
                     end else begin
                        addr_in  = {cur_addr[7:0], b};
                        dc_in    = 2'd0;
                        phase_in = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     rtype_in = b;
                     sum_in   = cur_sum + b;
                     dc_in    = 2'd0;
                     idx_in   = 8'd0;
                     phase_in = (cur_count == 8'd0) ? PH_CSUM : PH_DATA;
                  end
                  PH_DATA: begin
                     sum_in    = cur_sum + b;
                     res_valid = 1'b1;
                     res_kind  = KIND_DATA;
                     res_data  = b;
                     res_addr  = cur_addr + {8'd0, cur_idx};
                     res_type  = cur_rtype;
                     idx_in    = idx_inc;
                     dc_in     = 2'd0;
                     if (idx_inc == cur_count) begin
                        phase_in = PH_CSUM;
                     end
                  end
                  default: begin
                     dc_in     = 2'd0;
                     res_valid = 1'b1;
                     res_addr  = cur_addr;
                     res_type  = cur_rtype;
                     res_rsum  = b;
                     res_csum  = comp;
                     if (cur_rtype == TYPE_EOF) begin
                        phase_in = PH_HALT;
                        res_kind = KIND_EOF;
                     end else begin
                        if ((cur_rtype == TYPE_DATA) && !cur_seen) begin
                           flen_in = cur_count;
                           seen_in = 1'b1;
                        end
                        if (b != comp) begin
                           phase_in = PH_HALT;
                           res_kind = KIND_BAD;
                        end else begin
                           phase_in = PH_SKIP;
                           res_kind = KIND_OK;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         high_ff      <= '0;
         dc_ff        <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         rtype_ff     <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         flen_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (word_pop) begin
            phase_ff <= phase_in;
            high_ff  <= high_in;
            dc_ff    <= dc_in;
            count_ff <= count_in;
            addr_ff  <= addr_in;
            rtype_ff <= rtype_in;
            idx_ff   <= idx_in;
            sum_ff   <= sum_in;
            flen_ff  <= flen_in;
            seen_ff  <= seen_in;
         end
         if (out_free) begin
            rsp_valid_ff <= word_pop && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (word_pop && res_valid) begin
         kind_ff  <= res_kind;
         data_ff  <= res_data;
         baddr_ff <= res_addr;
         otype_ff <= res_type;
         rsum_ff  <= res_rsum;
         csum_ff  <= res_csum;
         oflen_ff <= flen_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_data_byte         = data_ff;
   assign rsp_byte_address      = baddr_ff;
   assign rsp_record_type       = otype_ff;
   assign rsp_record_checksum   = rsum_ff;
   assign rsp_computed_checksum = csum_ff;
   assign rsp_first_data_length = oflen_ff;

endmodule

// ===== hw/rtl/intel_hex_record_parser_top.sv =====
// top level of the intel hex record parser: front end, word queue, record engine
// a result is registered onto the rsp port when the record engine takes its word from the word queue
// throughput: one character word per cycle while the rsp side is not stalled, set by the one-step record engine
// the word queue absorbs up to QUEUE_DEPTH words while the rsp side stalls
// reset: synchronous, active high; clears the queue, parser state and rsp_valid
`timescale 1ns / 1ps

module intel_hex_record_parser_top
   import ihex_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_new_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_record_checksum,
   output logic [7:0]  rsp_computed_checksum,
   output logic [7:0]  rsp_first_data_length
);

   word_type front_word;
   word_type head_word;
   logic     queue_full;
   logic     head_valid;
   logic     head_pop;

   assign req_ready = !queue_full;

   ihex_front u_front (
      .char_in  (req_char_in),
      .new_file (req_new_file),
      .word     (front_word)
   );

   ihex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_word  (front_word),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   ihex_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .word_valid            (head_valid),
      .word                  (head_word),
      .word_pop              (head_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_data_byte         (rsp_data_byte),
      .rsp_byte_address      (rsp_byte_address),
      .rsp_record_type       (rsp_record_type),
      .rsp_record_checksum   (rsp_record_checksum),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_first_data_length (rsp_first_data_length)
   );

endmodule
